// ===== hw/rtl/fcra_pkg.sv =====
package fcra_pkg;

  // Fixed field widths of the request, result and register ports
  localparam int IDX_W    = 12;
  localparam int OUT_W    = 5;
  localparam int MAXCFG_W = 5;
  localparam int GSZ_W    = 13;

  // Histogram counters saturate instead of wrapping
  localparam int                CNT_W   = 13;
  localparam logic [CNT_W-1:0]  CNT_MAX = '1;

  // Register map: one 32-bit register per word address
  localparam int   APB_AW      = 3;
  localparam logic REG_MAX_RUN = 1'b0;
  localparam logic REG_GROUP   = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ALREADY  = 2'd1,
    STAT_RANGE    = 2'd2,
    STAT_DISABLED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_HIST
  } state_t;

  // Bitmap words are the run cap rounded up to a power of two
  function automatic int word_shift(int max_run);
    return $clog2(max_run);
  endfunction

  function automatic int map_rows(int blocks, int max_run);
    int sh;
    sh = $clog2(max_run);
    return (blocks + (1 << sh) - 1) >> sh;
  endfunction

  function automatic int addr_bits(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ===== hw/rtl/fcra_scan.sv =====
module fcra_scan #(
  parameter int BLOCKS  = 4096,
  parameter int MAX_RUN = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  logic [fcra_pkg::IDX_W-1:0]          blk,
  input  logic [$clog2(MAX_RUN+1)-1:0]        mx,
  input  logic [fcra_pkg::GSZ_W-1:0]          gsz,
  input  logic                                clr_en,
  input  logic [fcra_pkg::addr_bits(fcra_pkg::map_rows(BLOCKS, MAX_RUN))-1:0] clr_addr,
  output logic                                done,
  output logic                                already,
  output logic [$clog2(MAX_RUN+1)-1:0]        forw,
  output logic [$clog2(MAX_RUN+1)-1:0]        back
);
  import fcra_pkg::*;

  localparam int WSH    = word_shift(MAX_RUN);
  localparam int WORD_W = 1 << WSH;
  localparam int ROWS   = map_rows(BLOCKS, MAX_RUN);
  localparam int RAW    = addr_bits(ROWS);
  localparam int OFFW   = (WSH > 0) ? WSH : 1;
  localparam int RW     = $clog2(MAX_RUN + 1);
  localparam int WIN_W  = 3 * WORD_W;
  localparam int PW     = $clog2(WIN_W + 1);

  logic [WORD_W-1:0] mem [ROWS];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] mid;
  logic [WORD_W-1:0] hi;
  logic [WIN_W-1:0]  win;
  logic [WIN_W-1:0]  fsh;
  logic [WIN_W-1:0]  bsh;
  logic [PW-1:0]     pos;
  logic [IDX_W-1:0]  b_q;
  logic [4:0]        stg;
  logic [RAW-1:0]    row;
  logic [RAW-1:0]    raddr;
  logic [RAW-1:0]    waddr;
  logic [WORD_W-1:0] wdata;
  logic              wen;
  logic [OFFW-1:0]   off;
  logic              lo_ok;
  logic              hi_ok;
  logic [GSZ_W-1:0]  lim;
  logic [RW-1:0]     fcap;
  logic [MAX_RUN-1:0] fv_next;
  logic [MAX_RUN-1:0] bv_next;
  logic               own_next;
  logic [MAX_RUN-1:0] fv;
  logic [MAX_RUN-1:0] bv;
  logic               own;
  logic [RW-1:0]      forw_next;
  logic [RW-1:0]      back_next;

  assign row   = RAW'(b_q >> WSH);
  assign off   = OFFW'(b_q & IDX_W'(WORD_W - 1));
  assign lo_ok = (b_q >> WSH) != '0;
  assign hi_ok = (int'(b_q >> WSH) + 1) < ROWS;

  // Read the neighbor rows around the block one after another
  always_comb begin
    raddr = row;
    if (stg[0] && lo_ok) begin
      raddr = row - 1'b1;
    end else if (stg[2] && hi_ok) begin
      raddr = row + 1'b1;
    end
  end

  always_comb begin
    wen   = clr_en || (stg[4] && !own);
    waddr = clr_en ? clr_addr : row;
    wdata = clr_en ? '0 : (mid | (WORD_W'(1) << off));
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Window of three rows with the freed block in the middle row
  always_comb begin
    hi   = hi_ok ? rdata : '0;
    win  = {hi, mid, lo};
    pos  = PW'(WORD_W) + PW'(off);
    fsh  = win >> (pos + 1'b1);
    bsh  = win >> (pos - PW'(MAX_RUN));
    lim  = gsz - GSZ_W'(b_q) - 1'b1;
    fcap = (lim < GSZ_W'(mx)) ? RW'(lim) : mx;
    own_next = mid[off];
    for (int i = 0; i < MAX_RUN; i++) begin
      fv_next[i] = fsh[i] && (RW'(i) < fcap);
      bv_next[i] = bsh[MAX_RUN-1-i] && (RW'(i) < mx);
    end
  end

  // Run length is the position of the first clear bit
  always_comb begin
    forw_next = RW'(MAX_RUN);
    back_next = RW'(MAX_RUN);
    for (int i = MAX_RUN - 1; i >= 0; i--) begin
      if (!fv[i]) begin
        forw_next = RW'(i);
      end
      if (!bv[i]) begin
        back_next = RW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg  <= '0;
      done <= 1'b0;
    end else begin
      stg  <= {stg[3:0], go};
      done <= stg[4];
    end
    if (go) begin
      b_q <= blk;
    end
    if (stg[1]) begin
      lo <= lo_ok ? rdata : '0;
    end
    if (stg[2]) begin
      mid <= rdata;
    end
    if (stg[3]) begin
      fv  <= fv_next;
      bv  <= bv_next;
      own <= own_next;
    end
    if (stg[4]) begin
      forw    <= forw_next;
      back    <= back_next;
      already <= own;
    end
  end

endmodule

// ===== hw/rtl/fcra_hist.sv =====
module fcra_hist #(
  parameter int MAX_RUN = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [$clog2(MAX_RUN+1)-1:0] total,
  input  logic [$clog2(MAX_RUN+1)-1:0] back_len,
  input  logic [$clog2(MAX_RUN+1)-1:0] forw_len,
  input  logic [$clog2(MAX_RUN+1)-1:0] mx,
  input  logic                         clr_en,
  input  logic [$clog2(MAX_RUN+1)-1:0] clr_addr,
  output logic                         done,
  output logic [$clog2(MAX_RUN+1)-1:0] longest
);
  import fcra_pkg::*;

  localparam int HD = MAX_RUN + 1;
  localparam int RW = $clog2(MAX_RUN + 1);

  logic [CNT_W-1:0] mem [HD];
  logic [CNT_W-1:0] rdata;
  logic [RW-1:0]    a0;
  logic [RW-1:0]    a1;
  logic [RW-1:0]    a2;
  logic             e1;
  logic             e2;
  logic [4:0]       stg;
  logic [CNT_W-1:0] n0;
  logic [CNT_W-1:0] n1;
  logic [CNT_W-1:0] n0_next;
  logic [CNT_W-1:0] n1_next;
  logic [CNT_W-1:0] n2_next;
  logic [CNT_W-1:0] base1;
  logic [CNT_W-1:0] base2;
  logic [HD-1:0]    nz;
  logic [RW-1:0]    raddr;
  logic [RW-1:0]    waddr;
  logic [CNT_W-1:0] wdata;
  logic             wen;
  logic [RW-1:0]    best;

  always_comb begin
    raddr = a0;
    if (stg[1]) begin
      raddr = a1;
    end else if (stg[2]) begin
      raddr = a2;
    end
  end

  // Forward the write that lands on the same edge as the next read
  always_comb begin
    base1   = (a1 == a0) ? n0 : rdata;
    base2   = (e1 && (a2 == a1)) ? n1 : rdata;
    n0_next = (rdata == CNT_MAX) ? rdata : rdata + 1'b1;
    n1_next = (base1 == '0) ? base1 : base1 - 1'b1;
    n2_next = (base2 == '0) ? base2 : base2 - 1'b1;
  end

  always_comb begin
    wen   = 1'b0;
    waddr = a0;
    wdata = n0_next;
    if (clr_en) begin
      wen   = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (stg[1]) begin
      wen   = 1'b1;
      waddr = a0;
      wdata = n0_next;
    end else if (stg[2]) begin
      wen   = e1;
      waddr = a1;
      wdata = n1_next;
    end else if (stg[3]) begin
      wen   = e2;
      waddr = a2;
      wdata = n2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Highest nonzero length at or below the cap
  always_comb begin
    best = '0;
    for (int k = 1; k <= MAX_RUN; k++) begin
      if (nz[k] && (RW'(k) <= mx)) begin
        best = RW'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg     <= '0;
      done    <= 1'b0;
      nz      <= '0;
      longest <= '0;
    end else begin
      stg  <= {stg[3:0], go};
      done <= stg[4];
      if (wen) begin
        nz[waddr] <= |wdata;
      end
      if (stg[4]) begin
        longest <= best;
      end
    end
    if (go) begin
      a0 <= total;
      a1 <= back_len;
      a2 <= forw_len;
      e1 <= back_len != '0;
      e2 <= forw_len != '0;
    end
    if (stg[1]) begin
      n0 <= n0_next;
    end
    if (stg[2]) begin
      n1 <= n1_next;
    end
  end

endmodule

// ===== hw/rtl/free_cluster_run_accounting_core.sv =====
// Free-run accounting core: tracks a per-block free bitmap and a histogram
// of free-run lengths for one group of blocks.
//
// Request channel: drive block_index and pulse start; the request is taken
// at the clock edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle with forward_run,
// backward_run, longest_run and status valid. The receiver cannot stall.
// Config: APB-style port, max_run_length at 0x0, group_block_count at 0x4.
// Write only while busy is low and no result is outstanding.
//
// A successful free runs the three-row bitmap read, count and write-back,
// then the three histogram read-modify-writes and the longest-run search.
// An already-free block ends after the bitmap scan; a disabled or
// out-of-range request is answered straight from idle. A new request is
// taken in the cycle done rises.
// Reset: a clearing pass zeroes both memories, stepping over
// max(ceil(BLOCKS/W), MAX_RUN+1) addresses with W the run cap rounded up
// to a power of two (256 at defaults); busy stays high meanwhile.
module free_cluster_run_accounting_core #(
  parameter int BLOCKS  = 4096,
  parameter int MAX_RUN = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fcra_pkg::IDX_W-1:0]    block_index,
  output logic                          busy,
  output logic                          done,
  output logic [fcra_pkg::OUT_W-1:0]    forward_run,
  output logic [fcra_pkg::OUT_W-1:0]    backward_run,
  output logic [fcra_pkg::OUT_W-1:0]    longest_run,
  output logic [1:0]                    status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcra_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import fcra_pkg::*;

  localparam int RW      = $clog2(MAX_RUN + 1);
  localparam int ROWS    = map_rows(BLOCKS, MAX_RUN);
  localparam int RAW     = addr_bits(ROWS);
  localparam int HD      = MAX_RUN + 1;
  localparam int CLR_LEN = (ROWS > HD) ? ROWS : HD;
  localparam int CLW     = addr_bits(CLR_LEN);

  state_t            state;
  state_t            state_next;
  logic [MAXCFG_W-1:0] max_run_length;
  logic [GSZ_W-1:0]  group_block_count;
  logic [RW-1:0]     mx;
  logic [GSZ_W-1:0]  gsz;
  logic              in_range;
  logic [CLW-1:0]    clr_cnt;
  logic              map_clr;
  logic              hist_clr;
  logic              scan_go;
  logic              hist_go;
  logic              res_load;
  status_t           res_status;
  logic              scan_done;
  logic              already;
  logic [RW-1:0]     scan_forw;
  logic [RW-1:0]     scan_back;
  logic              hist_done;
  logic [RW-1:0]     hist_longest;
  logic [RW:0]       run_sum;
  logic [RW-1:0]     total;
  logic              cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_run_length    <= MAXCFG_W'(16);
      group_block_count <= GSZ_W'(4096);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MAX_RUN: max_run_length    <= pwdata[MAXCFG_W-1:0];
        REG_GROUP:   group_block_count <= pwdata[GSZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_RUN: prdata = 32'(max_run_length);
      REG_GROUP:   prdata = 32'(group_block_count);
      default:     prdata = '0;
    endcase
  end

  // Clamp the registers to what the memories can hold
  assign mx  = (int'(max_run_length) > MAX_RUN) ? RW'(MAX_RUN) : RW'(max_run_length);
  assign gsz = (int'(group_block_count) > BLOCKS) ? GSZ_W'(BLOCKS) : group_block_count;
  assign in_range = GSZ_W'(block_index) < gsz;

  // Joined run, capped at the maximum, goes into the histogram
  assign run_sum = (RW+1)'(scan_back) + (RW+1)'(scan_forw) + 1'b1;
  assign total   = (run_sum > (RW+1)'(mx)) ? mx : RW'(run_sum);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == CLW'(CLR_LEN - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start && (mx != '0) && in_range) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = already ? ST_IDLE : ST_HIST;
        end
      end
      ST_HIST: begin
        if (hist_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Disabled and range errors answer from idle, already-free after the scan; a good free runs scan then histogram
  always_comb begin
    busy       = 1'b1;
    scan_go    = 1'b0;
    hist_go    = 1'b0;
    res_load   = 1'b0;
    res_status = STAT_OK;
    map_clr    = 1'b0;
    hist_clr   = 1'b0;
    case (state)
      ST_CLEAR: begin
        map_clr  = int'(clr_cnt) < ROWS;
        hist_clr = int'(clr_cnt) < HD;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (mx == '0) begin
            res_load   = 1'b1;
            res_status = STAT_DISABLED;
          end else if (!in_range) begin
            res_load   = 1'b1;
            res_status = STAT_RANGE;
          end else begin
            scan_go = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (already) begin
            res_load   = 1'b1;
            res_status = STAT_ALREADY;
          end else begin
            hist_go = 1'b1;
          end
        end
      end
      ST_HIST: begin
        if (hist_done) begin
          res_load   = 1'b1;
          res_status = STAT_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_load;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
    // Error results report zero runs and the held longest run
    if (res_load) begin
      status       <= res_status;
      forward_run  <= (res_status == STAT_OK) ? OUT_W'(scan_forw) : '0;
      backward_run <= (res_status == STAT_OK) ? OUT_W'(scan_back) : '0;
      longest_run  <= OUT_W'(hist_longest);
    end
  end

  fcra_scan #(
    .BLOCKS  (BLOCKS),
    .MAX_RUN (MAX_RUN)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .go       (scan_go),
    .blk      (block_index),
    .mx       (mx),
    .gsz      (gsz),
    .clr_en   (map_clr),
    .clr_addr (RAW'(clr_cnt)),
    .done     (scan_done),
    .already  (already),
    .forw     (scan_forw),
    .back     (scan_back)
  );

  fcra_hist #(
    .MAX_RUN (MAX_RUN)
  ) u_hist (
    .clk      (clk),
    .rst      (rst),
    .go       (hist_go),
    .total    (total),
    .back_len (scan_back),
    .forw_len (scan_forw),
    .mx       (mx),
    .clr_en   (hist_clr),
    .clr_addr (RW'(clr_cnt)),
    .done     (hist_done),
    .longest  (hist_longest)
  );

  a_scan_done_waits: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> state == ST_SCAN)
    else $error("bitmap scan finished outside the scan state");

  a_hist_done_waits: assert property (@(posedge clk) disable iff (rst)
    hist_done |-> state == ST_HIST)
    else $error("histogram update finished outside the histogram state");

  a_error_zero_runs: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STAT_OK)) |-> (forward_run == '0) && (backward_run == '0))
    else $error("error result carries nonzero runs");

  a_ok_after_hist: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_OK)) |-> $past(hist_done))
    else $error("ok result without a histogram update");

endmodule

// ===== test/tb_free_cluster_run_accounting_core.sv =====
module tb_free_cluster_run_accounting_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fcra_pkg::*;

  localparam int BLOCKS      = 4096;
  localparam int MAX_RUN     = 16;
  localparam int CYCLE_LIMIT = 600000;

  // One expected result per free request
  typedef struct packed {
    logic [OUT_W-1:0] fwd;
    logic [OUT_W-1:0] bwd;
    logic [OUT_W-1:0] longest;
    status_t          st;
  } free_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [IDX_W-1:0]  block_index = '0;
  logic              busy;
  logic              done;
  logic [OUT_W-1:0]  forward_run;
  logic [OUT_W-1:0]  backward_run;
  logic [OUT_W-1:0]  longest_run;
  logic [1:0]        status;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  free_cluster_run_accounting_core #(
    .BLOCKS (BLOCKS),
    .MAX_RUN(MAX_RUN)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .block_index (block_index),
    .busy        (busy),
    .done        (done),
    .forward_run (forward_run),
    .backward_run(backward_run),
    .longest_run (longest_run),
    .status      (status),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the block's state and registers
  bit                free_map [BLOCKS];
  bit [CNT_W-1:0]    run_count [MAX_RUN+1];
  bit [OUT_W-1:0]    longest_held;
  logic [MAXCFG_W-1:0] cap_cfg = 5'd16;
  logic [GSZ_W-1:0]    group_cfg = 13'd4096;

  logic [IDX_W-1:0]  blocks_to_free [$];
  free_result_t      runs_due [$];

  int  mismatches = 0;
  int  queued_total = 0;
  int  accepted_total = 0;
  int  cycles = 0;
  int  gap_left = 0;
  int  window_base = 40;
  bit  gaps_on = 1'b0;
  logic took = 1'b0;

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Free one block in the shadow state and work out the result it causes
  function automatic free_result_t account_free(input logic [IDX_W-1:0] idx);
    free_result_t r;
    int b, mx, gsz, fwd, bwd, total, k;
    b   = int'(idx);
    mx  = (int'(cap_cfg) > MAX_RUN) ? MAX_RUN : int'(cap_cfg);
    gsz = (int'(group_cfg) > BLOCKS) ? BLOCKS : int'(group_cfg);
    fwd = 0;
    bwd = 0;
    r.st = STAT_OK;
    // precedence: disabled, then range, then already free
    if (mx == 0)
      r.st = STAT_DISABLED;
    else if (b >= gsz)
      r.st = STAT_RANGE;
    else if (free_map[b])
      r.st = STAT_ALREADY;
    if (r.st == STAT_OK) begin
      free_map[b] = 1'b1;
      while (fwd < mx && b + 1 + fwd < gsz && free_map[b + 1 + fwd])
        fwd++;
      while (bwd < mx && bwd < b && free_map[b - 1 - bwd])
        bwd++;
      total = bwd + fwd + 1;
      if (total > mx)
        total = mx;
      // counters saturate at both ends
      if (run_count[total] != CNT_MAX)
        run_count[total]++;
      if (bwd > 0 && run_count[bwd] != 0)
        run_count[bwd]--;
      if (fwd > 0 && run_count[fwd] != 0)
        run_count[fwd]--;
      // search only lengths up to the effective cap
      k = mx;
      while (k > 0 && run_count[k] == 0)
        k--;
      longest_held = k[OUT_W-1:0];
    end
    r.fwd     = fwd[OUT_W-1:0];
    r.bwd     = bwd[OUT_W-1:0];
    r.longest = longest_held;
    return r;
  endfunction

  // Mostly back-to-back requests, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!gaps_on)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 4);
    if (r < 97)
      return $urandom_range(5, 16);
    return $urandom_range(30, 90);
  endfunction

  // Request driver: change inputs on the falling edge, hold start until taken
  always @(negedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else if (!start || took) begin
      if (gap_left > 0) begin
        // idle: drop start and scramble the index so it is not trusted
        start       <= 1'b0;
        block_index <= IDX_W'($urandom_range(0, BLOCKS - 1));
        gap_left    <= gap_left - 1;
      end else if (blocks_to_free.size() != 0) begin
        start       <= 1'b1;
        block_index <= blocks_to_free.pop_front();
        gap_left    <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results against the oldest expectation, then predict
  // the request taken on this same edge
  always @(posedge clk) begin : watch
    free_result_t want;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (done === 1'b1) begin
        if (runs_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result fwd %0d bwd %0d longest %0d status %0d",
                                  forward_run, backward_run, longest_run, status));
        end else begin
          want = runs_due.pop_front();
          if (forward_run !== want.fwd)
            flag_mismatch($sformatf("forward_run %0d, expected %0d", forward_run, want.fwd));
          if (backward_run !== want.bwd)
            flag_mismatch($sformatf("backward_run %0d, expected %0d", backward_run, want.bwd));
          if (longest_run !== want.longest)
            flag_mismatch($sformatf("longest_run %0d, expected %0d",
                                    longest_run, want.longest));
          if (status !== want.st)
            flag_mismatch($sformatf("status %0d, expected %s", status, want.st.name()));
        end
      end
      if (start && !busy) begin
        runs_due.push_back(account_free(block_index));
        accepted_total <= accepted_total + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Write a register, then read it back in the transfer right after
  task automatic set_register(input logic reg_sel, input int value);
    logic [31:0] want;
    if (reg_sel == REG_MAX_RUN) begin
      cap_cfg = value[MAXCFG_W-1:0];
      want    = {{(32-MAXCFG_W){1'b0}}, value[MAXCFG_W-1:0]};
    end else begin
      group_cfg = value[GSZ_W-1:0];
      want      = {{(32-GSZ_W){1'b0}}, value[GSZ_W-1:0]};
    end
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= want;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want)
      flag_mismatch($sformatf("register at %0d reads %0h, expected %0h",
                              {reg_sel, 2'b00}, prdata, want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic feed(input int idx);
    blocks_to_free.push_back(idx[IDX_W-1:0]);
    queued_total++;
  endtask

  // Wait for every queued request to be taken and answered
  task automatic settle();
    do @(negedge clk);
    while (accepted_total != queued_total || runs_due.size() != 0);
  endtask

  // One random phase: most frees land in a compact window so runs form,
  // merge and hit the cap; the rest probe the range check and far blocks
  task automatic run_phase(input int cap, input int grp, input int n, input int win);
    int gsz, r, i;
    set_register(REG_MAX_RUN, cap);
    set_register(REG_GROUP, grp);
    gsz = (grp > BLOCKS) ? BLOCKS : grp;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80)
        feed(window_base + $urandom_range(0, win - 1));
      else if (r < 90 && gsz < BLOCKS)
        feed($urandom_range(gsz, BLOCKS - 1));
      else
        feed($urandom_range(0, BLOCKS - 1));
    end
    settle();
    window_base += win + 4;
  endtask

  initial begin : stimulus
    int p, n, win, cap, grp, rim_grp;

    // Hold reset, then wait out the clearing pass
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (busy !== 1'b0);

    // Directed: group edges, a three-block join, repeat free
    gaps_on = 1'b0;
    set_register(REG_MAX_RUN, 16);
    set_register(REG_GROUP, 4096);
    feed(0);
    feed(0);
    feed(4095);
    feed(4094);
    feed(2);
    feed(1);
    feed(4093);
    settle();

    // Directed: tiny cap clips the backward scan and the joined run;
    // group above the block count acts as the full map
    set_register(REG_MAX_RUN, 2);
    set_register(REG_GROUP, 8191);
    feed(10);
    feed(12);
    feed(11);
    feed(13);
    settle();

    // Directed: disabled wins over everything, even an already-free block
    set_register(REG_MAX_RUN, 0);
    feed(500);
    feed(0);
    settle();

    // Directed: cap above the parameter, small group; range beats
    // already free, forward scan stops at the group edge
    set_register(REG_MAX_RUN, 31);
    set_register(REG_GROUP, 20);
    feed(25);
    feed(4095);
    feed(19);
    feed(18);
    feed(3);
    settle();

    // Directed: empty group
    set_register(REG_MAX_RUN, 1);
    set_register(REG_GROUP, 0);
    feed(0);
    settle();

    // Random phases, each with its own cap and group size
    for (p = 0; p < 14; p++) begin
      win     = $urandom_range(24, 96);
      n       = 135;
      gaps_on = (p % 3 != 1);
      rim_grp = window_base + win - $urandom_range(0, 2);
      case (p)
        0:       begin cap = 16; grp = 4096; end
        1:       begin cap = 31; grp = 8191; end
        2:       begin cap = 1;  grp = rim_grp; end
        3:       begin cap = 17; grp = rim_grp; end
        4:       begin cap = 2;  grp = 4097; end
        5:       begin cap = 0;  grp = 4096; n = 16; end
        6:       begin cap = 8;  grp = rim_grp; end
        7:       begin cap = 5;  grp = 1; n = 16; end
        8:       begin cap = 16; grp = rim_grp; end
        9:       begin cap = 3;  grp = window_base + $urandom_range(0, win); end
        10:      begin cap = 12; grp = 4096; end
        11:      begin cap = 16; grp = rim_grp; end
        12:      begin cap = 4;  grp = 4095; end
        default: begin cap = 16; grp = rim_grp; end
      endcase
      run_phase(cap, grp, n, win);
    end

    // Drain: let any stray result show up before the verdict
    settle();
    repeat (30) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fcra_pkg.sv
hw/rtl/fcra_scan.sv
hw/rtl/fcra_hist.sv
hw/rtl/free_cluster_run_accounting_core.sv
test/tb_free_cluster_run_accounting_core.sv
